>>> rtl/sorted_key_value_table_unit_macros.svh
// assertion macros for the sorted key-value table unit
// expects signals clk and rst in the scope of use
`ifndef SORTED_KEY_VALUE_TABLE_UNIT_MACROS_SVH
`define SORTED_KEY_VALUE_TABLE_UNIT_MACROS_SVH

// same-cycle implication
`define SKV_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SKV_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/skv_pkg.sv
// types and constants of the sorted key-value table unit
// no dependencies
package skv_pkg;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  localparam logic [KIND_W-1:0] KIND_FIND   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } skv_op_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  result_value;
    logic [STATUS_W-1:0] status;
    logic [OCC_W-1:0]    occupancy;
  } skv_result_t;

  typedef struct packed {
    logic cmp;
    logic ins;
    logic del;
  } skv_ctl_t;

endpackage

>>> rtl/skv_cell.sv
// one entry of the sorted chain: compare against the broadcast key and shift
// depends on skv_pkg
module skv_cell (
  input  logic                   clk,
  input  skv_pkg::skv_ctl_t      ctl,
  input  logic                   occupied,
  input  logic [skv_pkg::KEY_W-1:0]   bkey,
  input  logic [skv_pkg::VALUE_W-1:0] bvalue,
  input  logic                   lt_left,
  input  logic [skv_pkg::KEY_W-1:0]   left_key,
  input  logic [skv_pkg::VALUE_W-1:0] left_value,
  input  logic [skv_pkg::KEY_W-1:0]   right_key,
  input  logic [skv_pkg::VALUE_W-1:0] right_value,
  output logic [skv_pkg::KEY_W-1:0]   key,
  output logic [skv_pkg::VALUE_W-1:0] value,
  output logic                   lt,
  output logic                   eq,
  output logic [skv_pkg::VALUE_W-1:0] hit_value
);
  import skv_pkg::*;

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt <= occupied && (key < bkey);
      eq <= occupied && (key == bkey);
    end
    if (ctl.ins && !lt) begin
      if (lt_left) begin
        key   <= bkey;
        value <= bvalue;
      end else begin
        key   <= left_key;
        value <= left_value;
      end
    end
    if (ctl.del && !lt) begin
      key   <= right_key;
      value <= right_value;
    end
  end

  assign hit_value = eq ? value : '0;

endmodule

>>> rtl/sorted_key_value_table_unit.sv
// sorted key-value table unit: top level with the cell chain and sequencer
// depends on skv_pkg, skv_cell and sorted_key_value_table_unit_macros.svh
//
// One operation (find, insert, delete) is taken when start is high and busy
// is low. Each operation runs through capture, compare in every cell, hit and
// value reduction across the chain, then the shift of the chain. The result
// word shows for exactly one cycle with done high, in the cycle busy drops,
// so a new word may be started in that same cycle. The receiver cannot stall:
// results must be taken when done is high. Keys are kept ascending in slots 0
// to occupancy-1; an insert of a new key into a full table is refused with
// status full, a duplicate insert or missing key gives status 1.
module sorted_key_value_table_unit #(
  parameter int CAPACITY = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  skv_pkg::skv_op_t     op,
  output logic                 done,
  output skv_pkg::skv_result_t result
);
  import skv_pkg::*;

  `include "sorted_key_value_table_unit_macros.svh"

  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_SEL   = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t state, state_next;
  logic [CNT_W-1:0] count, count_next;
  skv_op_t op_reg;
  logic hit;
  logic [VALUE_W-1:0] hit_sel;
  skv_ctl_t ctl;

  logic [KEY_W-1:0]   cell_key   [CAPACITY];
  logic [VALUE_W-1:0] cell_value [CAPACITY];
  logic [VALUE_W-1:0] cell_hit   [CAPACITY];
  logic [CAPACITY-1:0] cell_lt, cell_eq;

  logic hit_any;
  logic [VALUE_W-1:0] hit_or;
  logic do_ins, do_del;
  skv_result_t result_next;

  assign busy = (state != S_IDLE);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic occ;
    assign occ = (CNT_W'(i) < count);
    if (i == 0) begin : g_first
      skv_cell u_cell (
        .clk, .ctl, .occupied(occ), .bkey(op_reg.key), .bvalue(op_reg.value),
        .lt_left(1'b1), .left_key(op_reg.key), .left_value(op_reg.value),
        .right_key(cell_key[i+1]), .right_value(cell_value[i+1]),
        .key(cell_key[i]), .value(cell_value[i]),
        .lt(cell_lt[i]), .eq(cell_eq[i]), .hit_value(cell_hit[i])
      );
    end else if (i == CAPACITY - 1) begin : g_last
      skv_cell u_cell (
        .clk, .ctl, .occupied(occ), .bkey(op_reg.key), .bvalue(op_reg.value),
        .lt_left(cell_lt[i-1]), .left_key(cell_key[i-1]), .left_value(cell_value[i-1]),
        .right_key(cell_key[i]), .right_value(cell_value[i]),
        .key(cell_key[i]), .value(cell_value[i]),
        .lt(cell_lt[i]), .eq(cell_eq[i]), .hit_value(cell_hit[i])
      );
    end else begin : g_mid
      skv_cell u_cell (
        .clk, .ctl, .occupied(occ), .bkey(op_reg.key), .bvalue(op_reg.value),
        .lt_left(cell_lt[i-1]), .left_key(cell_key[i-1]), .left_value(cell_value[i-1]),
        .right_key(cell_key[i+1]), .right_value(cell_value[i+1]),
        .key(cell_key[i]), .value(cell_value[i]),
        .lt(cell_lt[i]), .eq(cell_eq[i]), .hit_value(cell_hit[i])
      );
    end
  end

  always_comb begin
    hit_any = |cell_eq;
    hit_or  = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_or = hit_or | cell_hit[i];
    end
  end

  assign do_ins = (op_reg.kind == KIND_INSERT) && !hit && (count < CNT_W'(CAPACITY));
  assign do_del = (op_reg.kind == KIND_DELETE) && hit;

  always_comb begin
    ctl.cmp = (state == S_CMP);
    ctl.ins = (state == S_APPLY) && do_ins;
    ctl.del = (state == S_APPLY) && do_del;
  end

  always_comb begin
    state_next = state;
    count_next = count;
    case (state)
      S_IDLE:  if (start) state_next = S_CMP;
      S_CMP:   state_next = S_SEL;
      S_SEL:   state_next = S_APPLY;
      S_APPLY: begin
        state_next = S_IDLE;
        if (do_ins) count_next = count + 1'b1;
        else if (do_del) count_next = count - 1'b1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    result_next.result_value = '0;
    result_next.status       = ST_DONE;
    case (op_reg.kind)
      KIND_FIND: begin
        if (hit) result_next.result_value = hit_sel;
        else result_next.status = ST_MISS;
      end
      KIND_INSERT: begin
        if (hit) result_next.status = ST_MISS;
        else if (!do_ins) result_next.status = ST_FULL;
      end
      KIND_DELETE: begin
        if (hit) result_next.result_value = hit_sel;
        else result_next.status = ST_MISS;
      end
      default: result_next.status = ST_DONE;
    endcase
    result_next.occupancy = OCC_W'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      done  <= (state == S_APPLY);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) op_reg <= op;
    if (state == S_SEL) begin
      hit     <= hit_any;
      hit_sel <= hit_or;
    end
    if (state == S_APPLY) result <= result_next;
  end

  // checks
  `SKV_ASSERT_IMP(a_done_not_busy, done, !busy, "result shown while busy")
  `SKV_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted word did not raise busy")
  `SKV_ASSERT_IMP(a_full_count, done && result.status == ST_FULL,
                  count == CNT_W'(CAPACITY), "full status with free slots")
  `SKV_ASSERT_IMP(a_ins_count,
                  done && op_reg.kind == KIND_INSERT && result.status == ST_DONE,
                  count == $past(count) + 1'b1, "insert did not grow the table")

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// testbench for the sorted key-value table unit: directed and random find, insert, delete
// depends on skv_pkg and sorted_key_value_table_unit; checks every result word in order
module tb_top;
  import skv_pkg::*;

  localparam int TABLE_DEPTH = 64;
  localparam int POOL_SIZE = 128;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  skv_op_t op = '0;
  logic busy;
  logic done;
  skv_result_t result;

  sorted_key_value_table_unit #(
    .CAPACITY(TABLE_DEPTH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .op(op),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [KEY_W-1:0] key_tab[TABLE_DEPTH];
  logic [VALUE_W-1:0] val_tab[TABLE_DEPTH];
  int stored_count = 0;
  logic [KEY_W-1:0] key_pool[POOL_SIZE];
  skv_result_t expected_results[$];
  int err_count = 0;
  int cycle_count = 0;
  bit idle_on = 1'b0;

  function automatic skv_result_t apply_table_op(skv_op_t w);
    skv_result_t r;
    int pos;
    bit hit;
    r = '0;
    r.status = ST_DONE;
    pos = 0;
    while (pos < stored_count && key_tab[pos] < w.key) pos++;
    hit = (pos < stored_count) && (key_tab[pos] == w.key);
    case (w.kind)
      KIND_FIND: begin
        if (hit) r.result_value = val_tab[pos];
        else r.status = ST_MISS;
      end
      KIND_INSERT: begin
        if (hit) begin
          r.status = ST_MISS;
        end else if (stored_count >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = stored_count; i > pos; i--) begin
            key_tab[i] = key_tab[i-1];
            val_tab[i] = val_tab[i-1];
          end
          key_tab[pos] = w.key;
          val_tab[pos] = w.value;
          stored_count++;
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          r.result_value = val_tab[pos];
          for (int i = pos; i + 1 < stored_count; i++) begin
            key_tab[i] = key_tab[i+1];
            val_tab[i] = val_tab[i+1];
          end
          stored_count--;
        end else begin
          r.status = ST_MISS;
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(stored_count);
    return r;
  endfunction

  function automatic skv_op_t make_word(logic [KIND_W-1:0] kind, logic [KEY_W-1:0] key,
                                        logic [VALUE_W-1:0] value);
    skv_op_t w;
    w.kind = kind;
    w.key = key;
    w.value = value;
    return w;
  endfunction

  // when keys are held, half the time one of them, else one from a small pool or fully random
  function automatic logic [KEY_W-1:0] pick_key();
    if (stored_count > 0 && $urandom_range(0, 1) == 1)
      return key_tab[$urandom_range(0, stored_count - 1)];
    if ($urandom_range(0, 4) == 0)
      return $urandom();
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic skv_op_t random_word(int ins_pct, int del_pct);
    skv_op_t w;
    int roll;
    roll = $urandom_range(0, 99);
    w.key = pick_key();
    w.value = pick_value();
    if (roll < 2) w.kind = KIND_NOP;
    else if (roll < 2 + ins_pct) w.kind = KIND_INSERT;
    else if (roll < 2 + ins_pct + del_pct) w.kind = KIND_DELETE;
    else w.kind = KIND_FIND;
    return w;
  endfunction

  task automatic send_word(input skv_op_t w);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    start <= 1'b1;
    op <= w;
    do @(posedge clk); while (busy !== 1'b0);
    expected_results.push_back(apply_table_op(w));
  endtask

  task automatic run_random(int count, int ins_pct, int del_pct, bit idling);
    for (int n = 0; n < count; n++) begin
      if (n % 64 == 0) idle_on = idling && ($urandom_range(0, 1) == 1);
      send_word(random_word(ins_pct, del_pct));
    end
  endtask

  task automatic test_directed();
    idle_on = 1'b1;
    send_word(make_word(KIND_FIND, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(KIND_DELETE, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(KIND_INSERT, 32'h8000_0000, 32'h1234_5678));
    send_word(make_word(KIND_INSERT, 32'h0000_0000, 32'hFFFF_FFFF));
    send_word(make_word(KIND_INSERT, 32'hFFFF_FFFF, 32'h0000_0000));
    send_word(make_word(KIND_INSERT, 32'h7FFF_FFFF, 32'hA5A5_A5A5));
    // duplicate keeps the old value
    send_word(make_word(KIND_INSERT, 32'h0000_0000, 32'h5A5A_5A5A));
    send_word(make_word(KIND_FIND, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(KIND_FIND, 32'hFFFF_FFFF, 32'h0000_0000));
    send_word(make_word(KIND_FIND, 32'h0000_0001, 32'h0000_0000));
    send_word(make_word(KIND_NOP, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(KIND_DELETE, 32'h8000_0000, 32'h0000_0000));
    send_word(make_word(KIND_FIND, 32'h7FFF_FFFF, 32'hFFFF_FFFF));
    send_word(make_word(KIND_DELETE, 32'h0000_0000, 32'h0000_0000));
    send_word(make_word(KIND_DELETE, 32'hFFFF_FFFF, 32'h0000_0000));
    send_word(make_word(KIND_DELETE, 32'hFFFF_FFFF, 32'h0000_0000));
    send_word(make_word(KIND_FIND, 32'h7FFF_FFFF, 32'h0000_0000));
    send_word(make_word(KIND_DELETE, 32'h7FFF_FFFF, 32'h0000_0000));
    send_word(make_word(KIND_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_full_table();
    idle_on = 1'b1;
    while (stored_count < TABLE_DEPTH)
      send_word(make_word(KIND_INSERT, $urandom(), $urandom()));
    send_word(make_word(KIND_INSERT, $urandom(), pick_value()));
    send_word(make_word(KIND_INSERT, key_tab[0], pick_value()));
    send_word(make_word(KIND_INSERT, key_tab[TABLE_DEPTH-1], pick_value()));
    send_word(make_word(KIND_NOP, $urandom(), $urandom()));
    send_word(make_word(KIND_FIND, key_tab[TABLE_DEPTH-1], '0));
    send_word(make_word(KIND_DELETE, key_tab[TABLE_DEPTH/2], '0));
    send_word(make_word(KIND_INSERT, $urandom(), $urandom()));
    repeat (TABLE_DEPTH)
      send_word(make_word(KIND_DELETE, key_tab[$urandom_range(0, stored_count - 1)], '0));
  endtask

  task automatic test_random_mix();
    run_random(500, 45, 25, 1'b1);
  endtask

  task automatic test_drain();
    run_random(200, 10, 60, 1'b1);
  endtask

  task automatic test_refill();
    run_random(350, 60, 15, 1'b1);
  endtask

  task automatic test_back_to_back();
    run_random(100, 40, 30, 1'b0);
  endtask

  always @(posedge clk) begin
    skv_result_t want;
    if (!rst && done === 1'b1) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %p", result);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        if (result.result_value !== want.result_value) begin
          $error("result_value expected %h actual %h", want.result_value, result.result_value);
          err_count++;
        end
        if (result.status !== want.status) begin
          $error("status expected %0d actual %0d", want.status, result.status);
          err_count++;
        end
        if (result.occupancy !== want.occupancy) begin
          $error("occupancy expected %0d actual %0d", want.occupancy, result.occupancy);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sorted_key_value_table_unit");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_full_table();
    test_random_mix();
    test_drain();
    test_refill();
    test_back_to_back();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("PASS sorted_key_value_table_unit");
    end else begin
      $display("FAIL sorted_key_value_table_unit");
    end
    $finish;
  end

endmodule
